// File: hw/rtl/bounded_queue_with_priority_front_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the bounded queue with priority front
// Shared concurrent assertion forms used by the queue RTL.
// ----------------------------------------------------------------------------
`ifndef BOUNDED_QUEUE_WITH_PRIORITY_FRONT_TOP_ASSERT_SVH
`define BOUNDED_QUEUE_WITH_PRIORITY_FRONT_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BQPF_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define BQPF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/bqpf_pkg.sv
// ----------------------------------------------------------------------------
// Bounded queue with priority front: package
// Shared constants, codes and transaction types of the queue.
// ----------------------------------------------------------------------------
package bqpf_pkg;

  localparam int StoreDepth   = 8;
  localparam int ValueWidth   = 32;
  localparam int CountWidth   = $clog2(StoreDepth + 1);
  localparam int LimitWidth   = 4;
  localparam int CmpWidth     = (CountWidth > LimitWidth) ? CountWidth : LimitWidth;
  localparam logic [LimitWidth-1:0] LimitReset = LimitWidth'(5);

  typedef enum logic [1:0] {
    OpInsert    = 2'd0,
    OpRemove    = 2'd1,
    OpAbandon   = 2'd2,
    OpEmergency = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    StOk       = 3'd0,
    StLimit    = 3'd1,
    StEmpty    = 3'd2,
    StNotFound = 3'd3,
    StFull     = 3'd4
  } status_e;

  typedef struct packed {
    op_e                           opcode;
    logic signed [ValueWidth-1:0]  value;
  } req_t;

  typedef struct packed {
    logic signed [ValueWidth-1:0]  removed_value;
    status_e                       status;
    logic [CountWidth-1:0]         occupancy;
  } rsp_t;

  typedef struct packed {
    logic                          valid;
    logic                          emer;
    logic signed [ValueWidth-1:0]  value;
  } link_t;

  typedef struct packed {
    logic                          hit;
    logic                          emer;
  } srch_t;

  typedef struct packed {
    logic                          push_tail;
    logic                          push_head;
    logic                          pop_head;
    logic                          del;
    logic signed [ValueWidth-1:0]  value;
  } cmd_t;

endpackage

// File: hw/rtl/bqpf_cell.sv
// ----------------------------------------------------------------------------
// Bounded queue with priority front: storage cell
// Holds one entry and moves it towards or away from the head as commanded.
// ----------------------------------------------------------------------------
module bqpf_cell (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  bqpf_pkg::cmd_t  cmd_i,
  input  bqpf_pkg::link_t left_i,
  input  bqpf_pkg::link_t right_i,
  input  bqpf_pkg::srch_t srch_i,
  output bqpf_pkg::srch_t srch_o,
  output bqpf_pkg::link_t state_o
);

  logic                                   valid_q, valid_d;
  logic                                   emer_q, emer_d;
  logic signed [bqpf_pkg::ValueWidth-1:0] value_q, value_d;
  logic                                   mine;

  assign mine        = valid_q && (value_q == cmd_i.value);
  assign srch_o.hit  = srch_i.hit | mine;
  assign srch_o.emer = srch_i.hit ? srch_i.emer : emer_q;

  always_comb begin
    valid_d = valid_q;
    emer_d  = emer_q;
    value_d = value_q;
    if (cmd_i.push_tail) begin
      if (!valid_q && left_i.valid) begin
        valid_d = 1'b1;
        emer_d  = 1'b0;
        value_d = cmd_i.value;
      end
    end else if (cmd_i.push_head) begin
      valid_d = left_i.valid;
      emer_d  = left_i.emer;
      value_d = left_i.value;
    end else if (cmd_i.pop_head || (cmd_i.del && srch_o.hit)) begin
      valid_d = right_i.valid;
      emer_d  = right_i.emer;
      value_d = right_i.value;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      emer_q  <= 1'b0;
    end else begin
      valid_q <= valid_d;
      emer_q  <= emer_d;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign state_o.valid = valid_q;
  assign state_o.emer  = emer_q;
  assign state_o.value = value_q;

endmodule

// File: hw/rtl/bqpf_ctrl.sv
// ----------------------------------------------------------------------------
// Bounded queue with priority front: control
// Keeps the counts and the limit, decides each operation and registers the result.
// ----------------------------------------------------------------------------
module bqpf_ctrl (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 accept_i,
  input  bqpf_pkg::req_t                       req_i,
  input  logic                                 cfg_we_i,
  input  logic [bqpf_pkg::LimitWidth-1:0]      cfg_wdata_i,
  input  bqpf_pkg::link_t                      head_i,
  input  bqpf_pkg::srch_t                      srch_i,
  output bqpf_pkg::cmd_t                       cmd_o,
  output logic                                 rsp_valid_o,
  output bqpf_pkg::rsp_t                       rsp_o
);

  logic [bqpf_pkg::CountWidth-1:0] cnt_q, cnt_d;
  logic [bqpf_pkg::CountWidth-1:0] reg_q, reg_d;
  logic [bqpf_pkg::LimitWidth-1:0] limit_q;
  logic                            rsp_valid_q;
  bqpf_pkg::rsp_t                  rsp_q, rsp_d;
  logic                            empty, full, limit_hit;

  assign empty     = (cnt_q == '0);
  assign full      = (cnt_q == bqpf_pkg::CountWidth'(bqpf_pkg::StoreDepth));
  assign limit_hit = (bqpf_pkg::CmpWidth'(reg_q) >= bqpf_pkg::CmpWidth'(limit_q));

  always_comb begin
    cmd_o                 = '0;
    cmd_o.value           = req_i.value;
    cnt_d                 = cnt_q;
    reg_d                 = reg_q;
    rsp_d.removed_value   = '0;
    rsp_d.status          = bqpf_pkg::StOk;
    case (req_i.opcode)
      bqpf_pkg::OpInsert: begin
        if (limit_hit) begin
          rsp_d.status = bqpf_pkg::StLimit;
        end else if (full) begin
          rsp_d.status = bqpf_pkg::StFull;
        end else begin
          cmd_o.push_tail = accept_i;
          cnt_d           = cnt_q + 1'b1;
          reg_d           = reg_q + 1'b1;
        end
      end
      bqpf_pkg::OpRemove: begin
        if (empty) begin
          rsp_d.status = bqpf_pkg::StEmpty;
        end else begin
          cmd_o.pop_head      = accept_i;
          rsp_d.removed_value = head_i.value;
          cnt_d               = cnt_q - 1'b1;
          if (!head_i.emer && reg_q != '0) begin
            reg_d = reg_q - 1'b1;
          end
        end
      end
      bqpf_pkg::OpAbandon: begin
        if (empty) begin
          rsp_d.status = bqpf_pkg::StEmpty;
        end else if (!srch_i.hit) begin
          rsp_d.status = bqpf_pkg::StNotFound;
        end else begin
          cmd_o.del = accept_i;
          cnt_d     = cnt_q - 1'b1;
          if (!srch_i.emer && reg_q != '0) begin
            reg_d = reg_q - 1'b1;
          end
        end
      end
      bqpf_pkg::OpEmergency: begin
        if (full) begin
          rsp_d.status = bqpf_pkg::StFull;
        end else begin
          cmd_o.push_head = accept_i;
          cnt_d           = cnt_q + 1'b1;
        end
      end
      default: begin
        rsp_d.status = bqpf_pkg::StOk;
      end
    endcase
    rsp_d.occupancy = cnt_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      reg_q       <= '0;
      limit_q     <= bqpf_pkg::LimitReset;
      rsp_valid_q <= 1'b0;
    end else begin
      if (accept_i) begin
        cnt_q <= cnt_d;
        reg_q <= reg_d;
      end
      if (cfg_we_i) begin
        limit_q <= cfg_wdata_i;
      end
      rsp_valid_q <= accept_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      rsp_q <= rsp_d;
    end
  end

  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

`include "bounded_queue_with_priority_front_top_assert.svh"

  `BQPF_ASSERT_NOW(a_reg_le_cnt, clk_i, rst_ni, 1'b1, reg_q <= cnt_q,
                   "regular count exceeds entry count")
  `BQPF_ASSERT_NOW(a_cnt_le_depth, clk_i, rst_ni, 1'b1,
                   cnt_q <= bqpf_pkg::CountWidth'(bqpf_pkg::StoreDepth),
                   "entry count exceeds storage")
  `BQPF_ASSERT_NEXT(a_rsp_follows, clk_i, rst_ni, accept_i, rsp_valid_q,
                    "accepted transaction gave no result")
  `BQPF_ASSERT_NEXT(a_no_spurious, clk_i, rst_ni, !accept_i, !rsp_valid_q,
                    "result without a transaction")
  `BQPF_ASSERT_NOW(a_occ_match, clk_i, rst_ni, rsp_valid_q, rsp_q.occupancy == cnt_q,
                   "reported occupancy differs from count")

endmodule

// File: hw/rtl/bounded_queue_with_priority_front_top.sv
// ----------------------------------------------------------------------------
// Bounded queue with priority front: top level
// A row of storage cells with a control block that keeps counts and results.
// ----------------------------------------------------------------------------
// Usage:
// A command transaction is taken on a rising edge where start is high and busy
// is low; req_i carries the opcode and the value. Busy is never raised, so a
// new command may be given in every cycle: one transaction per clock.
// Each command gives exactly one result, presented on rsp_o for one cycle
// with rsp_valid_o high, in the cycle after the command was taken. The result
// cannot be held off by the receiver, who must take it in that cycle.
// All cells compare against the value at once, and the cells that move shift
// by one place in the same edge.
// The regular limit is written through cfg_we_i and cfg_wdata_i. The user must
// write it only while no command is in flight; the block does not enforce it.
// Reset empties the queue, clears the counts and sets the limit to five.
// ----------------------------------------------------------------------------
module bounded_queue_with_priority_front_top (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  output logic                            busy,
  input  bqpf_pkg::req_t                  req_i,
  output logic                            rsp_valid_o,
  output bqpf_pkg::rsp_t                  rsp_o,
  input  logic                            cfg_we_i,
  input  logic [bqpf_pkg::LimitWidth-1:0] cfg_wdata_i
);

  logic            accept;
  bqpf_pkg::cmd_t  cmd;
  bqpf_pkg::link_t head_in;
  bqpf_pkg::link_t cell_st [bqpf_pkg::StoreDepth];
  bqpf_pkg::srch_t srch    [bqpf_pkg::StoreDepth+1];

  assign busy   = 1'b0;
  assign accept = start & ~busy;

  assign head_in.valid = 1'b1;
  assign head_in.emer  = 1'b1;
  assign head_in.value = cmd.value;
  assign srch[0]       = '0;

  for (genvar i = 0; i < bqpf_pkg::StoreDepth; i++) begin : g_cell
    bqpf_pkg::link_t left, right;
    if (i == 0) begin : g_first
      assign left = head_in;
    end else begin : g_mid
      assign left = cell_st[i-1];
    end
    if (i == bqpf_pkg::StoreDepth - 1) begin : g_last
      assign right = '0;
    end else begin : g_inner
      assign right = cell_st[i+1];
    end
    bqpf_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .cmd_i   (cmd),
      .left_i  (left),
      .right_i (right),
      .srch_i  (srch[i]),
      .srch_o  (srch[i+1]),
      .state_o (cell_st[i])
    );
  end

  bqpf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .req_i       (req_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .head_i      (cell_st[0]),
    .srch_i      (srch[bqpf_pkg::StoreDepth]),
    .cmd_o       (cmd),
    .rsp_valid_o (rsp_valid_o),
    .rsp_o       (rsp_o)
  );

endmodule
